// ===== hw/rtl/bts_pkg.sv =====
`default_nettype none

package bts_pkg;

  // Table size default
  localparam int MAX_LABELS_DEF = 16;

  // Configuration register indexes
  localparam logic [1:0] CFG_ALERT_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_THROTTLE        = 2'd1;
  localparam logic [1:0] CFG_REPORT_FLOOR    = 2'd2;

  // Configuration reset values
  localparam logic [31:0] ALERT_THRESHOLD_RST = 32'd20000;
  localparam logic [31:0] THROTTLE_RST        = 32'd5000;
  localparam logic [31:0] REPORT_FLOOR_RST    = 32'd1000;

  // Result kinds
  localparam logic [2:0] KIND_OK           = 3'd0;
  localparam logic [2:0] KIND_ALERT        = 3'd1;
  localparam logic [2:0] KIND_THROTTLED    = 3'd2;
  localparam logic [2:0] KIND_FULL_DROPPED = 3'd3;
  localparam logic [2:0] KIND_REPORT_ENTRY = 3'd4;
  localparam logic [2:0] KIND_REPORT_END   = 3'd5;
  localparam logic [2:0] KIND_REPORT_EMPTY = 3'd6;

  // Input action codes
  localparam logic ACTION_RECORD = 1'b0;
  localparam logic ACTION_REPORT = 1'b1;

  // One table entry as held in the entry memory (key lives in the match array)
  typedef struct packed {
    logic [31:0] worst;
    logic [31:0] overruns;
    logic [31:0] last_alert;
  } bts_rec_t;

  // Read address source of the entry memory
  typedef enum logic [1:0] {
    RD_MATCH,
    RD_I,
    RD_J,
    RD_HIT
  } bts_rd_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic        in_ready;
    bts_rd_sel_t rd_sel;
    logic        rec_commit;
    logic        i_clr;
    logic        i_inc;
    logic        j_from_i;
    logic        j_inc;
    logic        best_init;
    logic        best_cmp;
    logic        swap_a;
    logic        swap_b;
    logic        emit_entry;
    logic        emit_end;
    logic        emit_empty;
  } bts_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_fire;
    logic in_action;
    logic out_free;
    logic used_zero;
    logic i_last;
    logic j_end;
    logic best_is_i;
  } bts_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bts_in_if.sv =====
`default_nettype none

interface bts_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] label_key;
  logic [31:0] elapsed_us;
  logic [31:0] now_ms;

  modport source (output valid, action, label_key, elapsed_us, now_ms, input ready);
  modport sink   (input valid, action, label_key, elapsed_us, now_ms, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bts_out_if.sv =====
`default_nettype none

interface bts_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] out_label;
  logic [31:0] time_us;
  logic [31:0] overrun_count;
  logic        last;

  modport source (output valid, kind, out_label, time_us, overrun_count, last, input ready);
  modport sink   (input valid, kind, out_label, time_us, overrun_count, last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bts_cfg_if.sv =====
`default_nettype none

interface bts_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/block_timing_stats_table_core.sv =====
`default_nettype none

// Timing statistics table, keyed by a 16-bit label number.
// Channels: in_chan takes record (action 0) and report (action 1) transactions;
// out_chan delivers results, with last high on the final result of each input;
// cfg_chan writes alert threshold, throttle window and report floor (index 0..2),
// always ready, to be used only while the block is idle.
// Record: the key is matched against all used entries in the accept cycle and
// the entry memory is read at that edge; once the output register is free, the
// entry is written back (unless dropped) and the result is loaded into that register.
// Report: a selection sort in place over the n used entries through the single
// memory read port, then a sweep giving one result per entry at or above the
// report floor and the end result, waiting while out_chan is busy; worst times are
// cleared during the emit sweep. An empty table gives a single report-empty result.
// Input is taken again as soon as the previous item's last result is loaded in
// the output register, even while that result still waits; a stalled receiver
// holds the block only at the steps that may load a result.
// Reset: the table is emptied (fill count zero), configuration returns to its
// default values, and the output register is empty. No clearing pass is needed.
module block_timing_stats_table_core
  import bts_pkg::*;
#(
  parameter int MAX_LABELS = MAX_LABELS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bts_in_if.sink     in_chan,
  bts_out_if.source  out_chan,
  bts_cfg_if.sink    cfg_chan
);

  bts_cmd_t cmd;
  bts_sts_t sts;

  bts_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  bts_dp #(
    .MAX_LABELS (MAX_LABELS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan),
    .cmd      (cmd),
    .sts      (sts)
  );

  // One item at a time: no new transaction right after one is taken
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("input taken while an item is in work");

  // A result is only loaded when the output register is free
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rec_commit || cmd.emit_entry || cmd.emit_end || cmd.emit_empty) |-> sts.out_free)
    else $error("result loaded over a pending result");

  // Only report entries leave last low
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.last) |-> (out_chan.kind == KIND_REPORT_ENTRY))
    else $error("non-entry result without last");

  // A swap's first write is always followed by its second write
  a_swap_seq: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.swap_a |=> cmd.swap_b)
    else $error("swap not completed");

endmodule

`default_nettype wire

// ===== hw/rtl/bts_ctrl.sv =====
`default_nettype none

module bts_ctrl
  import bts_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  bts_sts_t      sts,
  output bts_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_REC,
    S_RSTART,
    S_EMPTY,
    S_PCHK,
    S_PRD,
    S_PINIT,
    S_SRD,
    S_SCMP,
    S_SSW,
    S_SSWB,
    S_NEXT,
    S_ERD,
    S_EEMIT,
    S_EEND
  } state_t;

  state_t state_r, state_nxt;

  // Sequence commands and next state
  always_comb begin
    cmd       = '0;
    cmd.rd_sel = RD_I;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.rd_sel   = RD_MATCH;
        if (sts.in_fire) begin
          state_nxt = (sts.in_action == ACTION_REPORT) ? S_RSTART : S_REC;
        end
      end
      // Keep the matched entry on the read port while the output is busy
      S_REC: begin
        cmd.rd_sel = RD_HIT;
        if (sts.out_free) begin
          cmd.rec_commit = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_RSTART: begin
        if (sts.used_zero) begin
          state_nxt = S_EMPTY;
        end else begin
          cmd.i_clr = 1'b1;
          state_nxt = S_PCHK;
        end
      end
      S_EMPTY: begin
        if (sts.out_free) begin
          cmd.emit_empty = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      // Last position needs no pass: go to the emit sweep
      S_PCHK: begin
        if (sts.i_last) begin
          cmd.i_clr = 1'b1;
          state_nxt = S_ERD;
        end else begin
          state_nxt = S_PRD;
        end
      end
      S_PRD: begin
        cmd.rd_sel = RD_I;
        state_nxt  = S_PINIT;
      end
      S_PINIT: begin
        cmd.best_init = 1'b1;
        cmd.j_from_i  = 1'b1;
        state_nxt     = S_SRD;
      end
      S_SRD: begin
        if (sts.j_end) begin
          state_nxt = S_SSW;
        end else begin
          cmd.rd_sel = RD_J;
          state_nxt  = S_SCMP;
        end
      end
      S_SCMP: begin
        cmd.best_cmp = 1'b1;
        cmd.j_inc    = 1'b1;
        state_nxt    = S_SRD;
      end
      S_SSW: begin
        if (!sts.best_is_i) begin
          cmd.swap_a = 1'b1;
          state_nxt  = S_SSWB;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_SSWB: begin
        cmd.swap_b = 1'b1;
        state_nxt  = S_NEXT;
      end
      S_NEXT: begin
        cmd.i_inc = 1'b1;
        state_nxt = S_PCHK;
      end
      S_ERD: begin
        cmd.rd_sel = RD_I;
        state_nxt  = S_EEMIT;
      end
      S_EEMIT: begin
        if (sts.out_free) begin
          cmd.emit_entry = 1'b1;
          if (sts.i_last) begin
            state_nxt = S_EEND;
          end else begin
            cmd.i_inc = 1'b1;
            state_nxt = S_ERD;
          end
        end
      end
      S_EEND: begin
        if (sts.out_free) begin
          cmd.emit_end = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bts_dp.sv =====
`default_nettype none

module bts_dp
  import bts_pkg::*;
#(
  parameter int MAX_LABELS = MAX_LABELS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bts_in_if.sink     in_chan,
  bts_out_if.source  out_chan,
  bts_cfg_if.sink    cfg_chan,
  input  bts_cmd_t   cmd,
  output bts_sts_t   sts
);

  localparam int IW = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
  localparam int CW = $clog2(MAX_LABELS + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_LABELS);

  // Configuration registers
  logic [31:0] thr_r, throttle_r, floor_r;

  // Key match array and fill count
  logic [15:0]   key_r [MAX_LABELS];
  logic [CW-1:0] used_r;

  // Entry memory with registered read
  bts_rec_t mem [MAX_LABELS];
  bts_rec_t rdata_r;

  // Captured input transaction
  logic        act_r;
  logic [15:0] key_in_r;
  logic [31:0] el_r, now_r;
  logic [IW-1:0] hit_r;
  logic        found_r;

  // Sort and sweep counters
  logic [CW-1:0] i_r, j_r;
  logic [IW-1:0] best_r;
  bts_rec_t      best_rec_r, cur_rec_r;

  // Output register
  logic        out_valid_r;
  logic [2:0]  out_kind_r;
  logic [15:0] out_label_r;
  logic [31:0] out_time_r, out_cnt_r;
  logic        out_last_r;

  logic          in_fire, out_free;
  logic [MAX_LABELS-1:0] match;
  logic [IW-1:0] hit_idx;
  logic          hit_any;
  logic [IW-1:0] i_idx, rd_addr;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign i_idx    = i_r[IW-1:0];

  assign in_chan.ready  = cmd.in_ready;
  assign cfg_chan.ready = 1'b1;

  // Compare the incoming key against every used entry
  always_comb begin
    for (int k = 0; k < MAX_LABELS; k++) begin
      match[k] = (CW'(k) < used_r) && (key_r[k] == in_chan.label_key);
    end
  end

  // Pick the lowest matching entry
  always_comb begin
    hit_idx = '0;
    hit_any = 1'b0;
    for (int k = MAX_LABELS - 1; k >= 0; k--) begin
      if (match[k]) begin
        hit_idx = IW'(k);
        hit_any = 1'b1;
      end
    end
  end

  // Select the memory read address
  always_comb begin
    case (cmd.rd_sel)
      RD_MATCH: rd_addr = hit_idx;
      RD_HIT:   rd_addr = hit_r;
      RD_J:     rd_addr = j_r[IW-1:0];
      default:  rd_addr = i_idx;
    endcase
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
  end

  // Record update
  bts_rec_t      base, new_rec;
  logic [IW-1:0] rec_idx;
  logic          full, drop, over, expired, alert;
  logic [31:0]   cnt_inc, cnt_new;
  logic [2:0]    rec_kind;

  always_comb begin
    base     = found_r ? rdata_r : '0;
    rec_idx  = found_r ? hit_r : used_r[IW-1:0];
    full     = (used_r == FULL_CNT);
    drop     = !found_r && full;
    over     = el_r > thr_r;
    cnt_inc  = base.overruns + 32'd1;
    cnt_new  = over ? cnt_inc : base.overruns;
    expired  = (now_r - base.last_alert) >= throttle_r;
    alert    = over && ((cnt_inc == 32'd1) || expired);
    new_rec.worst      = (el_r > base.worst) ? el_r : base.worst;
    new_rec.overruns   = cnt_new;
    new_rec.last_alert = alert ? now_r : base.last_alert;
    if (drop) begin
      rec_kind = KIND_FULL_DROPPED;
    end else if (!over) begin
      rec_kind = KIND_OK;
    end else if (alert) begin
      rec_kind = KIND_ALERT;
    end else begin
      rec_kind = KIND_THROTTLED;
    end
  end

  // Memory write port
  logic          we;
  logic [IW-1:0] waddr;
  bts_rec_t      wdata;

  always_comb begin
    we    = 1'b0;
    waddr = i_idx;
    wdata = rdata_r;
    if (cmd.rec_commit && !drop) begin
      we    = 1'b1;
      waddr = rec_idx;
      wdata = new_rec;
    end else if (cmd.swap_a) begin
      we    = 1'b1;
      waddr = i_idx;
      wdata = best_rec_r;
    end else if (cmd.swap_b) begin
      we    = 1'b1;
      waddr = best_r;
      wdata = cur_rec_r;
    end else if (cmd.emit_entry) begin
      we          = 1'b1;
      waddr       = i_idx;
      wdata       = rdata_r;
      wdata.worst = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Insert new keys and swap keys with the sorted entries
  always_ff @(posedge clk) begin
    if (cmd.rec_commit && !drop && !found_r) begin
      key_r[rec_idx] <= key_in_r;
    end else if (cmd.swap_a) begin
      key_r[i_idx]  <= key_r[best_r];
      key_r[best_r] <= key_r[i_idx];
    end
  end

  // Advance the fill count on insert
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (cmd.rec_commit && !drop && !found_r) begin
      used_r <= used_r + CW'(1);
    end
  end

  // Capture the input transaction and its lookup
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r    <= in_chan.action;
      key_in_r <= in_chan.label_key;
      el_r     <= in_chan.elapsed_us;
      now_r    <= in_chan.now_ms;
      hit_r    <= hit_idx;
      found_r  <= hit_any;
    end
  end

  // Sort pass and sweep counters
  always_ff @(posedge clk) begin
    if (cmd.i_clr) begin
      i_r <= '0;
    end else if (cmd.i_inc) begin
      i_r <= i_r + CW'(1);
    end
    if (cmd.j_from_i) begin
      j_r <= i_r + CW'(1);
    end else if (cmd.j_inc) begin
      j_r <= j_r + CW'(1);
    end
    if (cmd.best_init) begin
      best_r     <= i_idx;
      best_rec_r <= rdata_r;
      cur_rec_r  <= rdata_r;
    end else if (cmd.best_cmp && (rdata_r.worst > best_rec_r.worst)) begin
      best_r     <= j_r[IW-1:0];
      best_rec_r <= rdata_r;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= ALERT_THRESHOLD_RST;
      throttle_r <= THROTTLE_RST;
      floor_r    <= REPORT_FLOOR_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        CFG_ALERT_THRESHOLD: thr_r      <= cfg_chan.wdata;
        CFG_THROTTLE:        throttle_r <= cfg_chan.wdata;
        CFG_REPORT_FLOOR:    floor_r    <= cfg_chan.wdata;
        default: ;
      endcase
    end
  end

  // Output register: load a result, drop it once taken
  logic emit_rep;
  assign emit_rep = cmd.emit_entry && (rdata_r.worst >= floor_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.rec_commit || emit_rep || cmd.emit_end || cmd.emit_empty) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rec_commit) begin
      out_kind_r  <= rec_kind;
      out_label_r <= key_in_r;
      out_time_r  <= el_r;
      out_cnt_r   <= drop ? 32'd0 : cnt_new;
      out_last_r  <= 1'b1;
    end else if (emit_rep) begin
      out_kind_r  <= KIND_REPORT_ENTRY;
      out_label_r <= key_r[i_idx];
      out_time_r  <= rdata_r.worst;
      out_cnt_r   <= rdata_r.overruns;
      out_last_r  <= 1'b0;
    end else if (cmd.emit_end || cmd.emit_empty) begin
      out_kind_r  <= cmd.emit_end ? KIND_REPORT_END : KIND_REPORT_EMPTY;
      out_label_r <= '0;
      out_time_r  <= '0;
      out_cnt_r   <= '0;
      out_last_r  <= 1'b1;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.kind          = out_kind_r;
  assign out_chan.out_label     = out_label_r;
  assign out_chan.time_us       = out_time_r;
  assign out_chan.overrun_count = out_cnt_r;
  assign out_chan.last          = out_last_r;

  // Status back to the controller
  always_comb begin
    sts.in_fire   = in_fire;
    sts.in_action = in_fire ? in_chan.action : act_r;
    sts.out_free  = out_free;
    sts.used_zero = (used_r == '0);
    sts.i_last    = ((CW + 1)'(i_r) + (CW + 1)'(1)) == (CW + 1)'(used_r);
    sts.j_end     = (j_r == used_r);
    sts.best_is_i = (best_r == i_idx);
  end

endmodule

`default_nettype wire

// ===== bench/block_timing_stats_table_core_tb.sv =====
module block_timing_stats_table_core_tb
  import bts_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 87;
  localparam int TAIL_CYCLES = 20;
  localparam longint TIMEOUT_NS = 64'd5_000_000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] label;
    logic [31:0] time_us;
    logic [31:0] count;
    logic        last;
  } result_t;

  typedef struct packed {
    logic        act;
    logic [15:0] key;
    logic [31:0] elapsed;
    logic [31:0] now_ms;
    logic        typed;
    result_t     want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bts_in_if  in_chan ();
  bts_out_if out_chan ();
  bts_cfg_if cfg_chan ();

  block_timing_stats_table_core #(
    .MAX_LABELS(MAX_LABELS_DEF)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // Predicted table contents and register values
  logic [15:0] tbl_key       [MAX_LABELS_DEF];
  logic [31:0] tbl_worst     [MAX_LABELS_DEF];
  logic [31:0] tbl_overruns  [MAX_LABELS_DEF];
  logic [31:0] tbl_last_alert[MAX_LABELS_DEF];
  int          tbl_used = 0;
  logic [31:0] cfg_threshold = ALERT_THRESHOLD_RST;
  logic [31:0] cfg_throttle  = THROTTLE_RST;
  logic [31:0] cfg_floor     = REPORT_FLOOR_RST;

  result_t expected_results[$];
  result_t want_res;
  int      mismatch_count = 0;
  bit      calm = 1'b0;
  bit      hold_request = 1'b0;
  logic [31:0] clock_ms = 32'd0;

  // Directed stimulus; typed rows carry a result that is obvious from the spec
  row_t directed_rows [24] = '{
    '{ACTION_REPORT, 16'h0000, 32'd0,          32'd0,          1'b1,
      '{KIND_REPORT_EMPTY, 16'h0000, 32'd0, 32'd0, 1'b1}},
    '{ACTION_RECORD, 16'h0000, 32'd0,          32'd0,          1'b1,
      '{KIND_OK, 16'h0000, 32'd0, 32'd0, 1'b1}},
    '{ACTION_RECORD, 16'hFFFF, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1,
      '{KIND_ALERT, 16'hFFFF, 32'hFFFF_FFFF, 32'd1, 1'b1}},
    '{ACTION_RECORD, 16'hFFFF, 32'd20001,      32'd3,          1'b0, '0},
    '{ACTION_RECORD, 16'hFFFF, 32'd20000,      32'd10,         1'b0, '0},
    '{ACTION_RECORD, 16'hFFFF, 32'd30000,      32'd5002,       1'b0, '0},
    '{ACTION_RECORD, 16'd1,    32'd5000,       32'd101,        1'b0, '0},
    '{ACTION_RECORD, 16'd2,    32'd5000,       32'd102,        1'b0, '0},
    '{ACTION_RECORD, 16'd3,    32'd900,        32'd103,        1'b0, '0},
    '{ACTION_RECORD, 16'd4,    32'd25000,      32'd104,        1'b0, '0},
    '{ACTION_RECORD, 16'd5,    32'd1000,       32'd105,        1'b0, '0},
    '{ACTION_RECORD, 16'd6,    32'd999,        32'd106,        1'b0, '0},
    '{ACTION_RECORD, 16'd7,    32'hFFFF_FFFF,  32'd107,        1'b0, '0},
    '{ACTION_RECORD, 16'd8,    32'd20001,      32'd108,        1'b0, '0},
    '{ACTION_RECORD, 16'd9,    32'd1,          32'd109,        1'b0, '0},
    '{ACTION_RECORD, 16'd10,   32'h8000_0000,  32'd110,        1'b0, '0},
    '{ACTION_RECORD, 16'd11,   32'd5000,       32'd111,        1'b0, '0},
    '{ACTION_RECORD, 16'd12,   32'd12345,      32'd112,        1'b0, '0},
    '{ACTION_RECORD, 16'd13,   32'h7FFF_FFFF,  32'd113,        1'b0, '0},
    '{ACTION_RECORD, 16'd14,   32'd0,          32'd114,        1'b0, '0},
    '{ACTION_RECORD, 16'h1234, 32'd777,        32'd6000,       1'b1,
      '{KIND_FULL_DROPPED, 16'h1234, 32'd777, 32'd0, 1'b1}},
    '{ACTION_RECORD, 16'd7,    32'd40000,      32'd6001,       1'b0, '0},
    '{ACTION_REPORT, 16'hA5A5, 32'h5A5A_5A5A,  32'd6002,       1'b0, '0},
    '{ACTION_REPORT, 16'h0000, 32'd0,          32'd6003,       1'b1,
      '{KIND_REPORT_END, 16'h0000, 32'd0, 32'd0, 1'b1}}
  };

  // Clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Count a mismatch and print it
  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  task automatic expect_result(input logic [2:0] kind, input logic [15:0] label,
                               input logic [31:0] t, input logic [31:0] cnt,
                               input logic last);
    result_t r;
    r.kind = kind;
    r.label = label;
    r.time_us = t;
    r.count = cnt;
    r.last = last;
    expected_results.push_back(r);
  endtask

  // Update the predicted table for one accepted transaction and queue its results
  task automatic stats_table_step(input logic act, input logic [15:0] key,
                                  input logic [31:0] el, input logic [31:0] now);
    int hit;
    int best;
    logic [15:0] tk;
    logic [31:0] tw, tov, tla;
    if (act == ACTION_RECORD) begin
      hit = -1;
      for (int i = 0; i < tbl_used; i++) begin
        if (hit < 0 && tbl_key[i] == key) hit = i;
      end
      if (hit < 0 && tbl_used >= MAX_LABELS_DEF) begin
        expect_result(KIND_FULL_DROPPED, key, el, 32'd0, 1'b1);
      end else begin
        if (hit < 0) begin
          hit = tbl_used;
          tbl_used++;
          tbl_key[hit] = key;
          tbl_worst[hit] = 32'd0;
          tbl_overruns[hit] = 32'd0;
          tbl_last_alert[hit] = 32'd0;
        end
        if (el > tbl_worst[hit]) tbl_worst[hit] = el;
        if (el <= cfg_threshold) begin
          expect_result(KIND_OK, key, el, tbl_overruns[hit], 1'b1);
        end else begin
          tbl_overruns[hit] = tbl_overruns[hit] + 32'd1;
          if (tbl_overruns[hit] != 32'd1 && (now - tbl_last_alert[hit]) < cfg_throttle) begin
            expect_result(KIND_THROTTLED, key, el, tbl_overruns[hit], 1'b1);
          end else begin
            tbl_last_alert[hit] = now;
            expect_result(KIND_ALERT, key, el, tbl_overruns[hit], 1'b1);
          end
        end
      end
    end else if (tbl_used == 0) begin
      expect_result(KIND_REPORT_EMPTY, 16'h0000, 32'd0, 32'd0, 1'b1);
    end else begin
      // Selection sort, descending, first strictly largest wins
      for (int i = 0; i < tbl_used; i++) begin
        best = i;
        for (int j = i + 1; j < tbl_used; j++) begin
          if (tbl_worst[j] > tbl_worst[best]) best = j;
        end
        if (best != i) begin
          tk = tbl_key[i];         tbl_key[i] = tbl_key[best];               tbl_key[best] = tk;
          tw = tbl_worst[i];       tbl_worst[i] = tbl_worst[best];           tbl_worst[best] = tw;
          tov = tbl_overruns[i];   tbl_overruns[i] = tbl_overruns[best];     tbl_overruns[best] = tov;
          tla = tbl_last_alert[i]; tbl_last_alert[i] = tbl_last_alert[best]; tbl_last_alert[best] = tla;
        end
      end
      for (int i = 0; i < tbl_used; i++) begin
        if (tbl_worst[i] >= cfg_floor) begin
          expect_result(KIND_REPORT_ENTRY, tbl_key[i], tbl_worst[i], tbl_overruns[i], 1'b0);
        end
      end
      expect_result(KIND_REPORT_END, 16'h0000, 32'd0, 32'd0, 1'b1);
      for (int i = 0; i < tbl_used; i++) tbl_worst[i] = 32'd0;
    end
  endtask

  // Offer one transaction after a random gap and hold it until taken
  task automatic offer_item(input logic act, input logic [15:0] key,
                            input logic [31:0] el, input logic [31:0] now);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.action     <= act;
    in_chan.label_key  <= key;
    in_chan.elapsed_us <= el;
    in_chan.now_ms     <= now;
    do @(posedge clk); while (!in_chan.ready);
    stats_table_step(act, key, el, now);
  endtask

  // Drop input valid and wait for every pending result
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Write all registers, plus the unused index which must be ignored
  task automatic set_registers(input logic [31:0] thr, input logic [31:0] thr_ms,
                               input logic [31:0] floor_us);
    logic [1:0]  idx_list [4];
    logic [31:0] val_list [4];
    idx_list = '{CFG_ALERT_THRESHOLD, CFG_THROTTLE, CFG_REPORT_FLOOR, CFG_UNUSED};
    val_list = '{thr, thr_ms, floor_us, $urandom};
    wait_idle();
    for (int k = 0; k < 4; k++) begin
      cfg_chan.valid <= 1'b1;
      cfg_chan.index <= idx_list[k];
      cfg_chan.wdata <= val_list[k];
      do @(posedge clk); while (!cfg_chan.ready);
      case (idx_list[k])
        CFG_ALERT_THRESHOLD: cfg_threshold = val_list[k];
        CFG_THROTTLE:        cfg_throttle = val_list[k];
        CFG_REPORT_FLOOR:    cfg_floor = val_list[k];
        default: ;
      endcase
    end
    cfg_chan.valid <= 1'b0;
  endtask

  // Elapsed time clustered around the alert threshold
  function automatic logic [31:0] draw_elapsed();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = cfg_threshold;
      2: v = cfg_threshold + 32'd1;
      3: v = cfg_threshold - 32'd1;
      4: v = $urandom_range(0, cfg_threshold);
      default: v = cfg_threshold + $urandom_range(1, 50000);
    endcase
    return v;
  endfunction

  // Mostly records on known labels, some unknown labels and some reports
  task automatic random_phase(input int n_items, input bit with_hold);
    int pick;
    logic act;
    logic [15:0] key;
    logic [31:0] el;
    for (int i = 0; i < n_items; i++) begin
      calm = (i >= 20 && i < 40);
      if (with_hold && i == 50) hold_request = 1'b1;
      if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
      else clock_ms = clock_ms + $urandom_range(0, 4000);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        act = ACTION_REPORT;
        key = 16'($urandom);
        el = $urandom;
      end else begin
        act = ACTION_RECORD;
        if (pick < 14) key = 16'($urandom);
        else key = tbl_key[$urandom_range(0, tbl_used - 1)];
        el = draw_elapsed();
      end
      offer_item(act, key, el, clock_ms);
    end
    calm = 1'b0;
  endtask

  // Main stimulus
  initial begin : stimulus
    in_chan.valid = 1'b0;
    in_chan.action = ACTION_RECORD;
    in_chan.label_key = 16'h0000;
    in_chan.elapsed_us = 32'd0;
    in_chan.now_ms = 32'd0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = CFG_ALERT_THRESHOLD;
    cfg_chan.wdata = 32'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows, at reset register values
    foreach (directed_rows[r]) begin
      offer_item(directed_rows[r].act, directed_rows[r].key,
                 directed_rows[r].elapsed, directed_rows[r].now_ms);
      if (directed_rows[r].typed) begin
        void'(expected_results.pop_back());
        expected_results.push_back(directed_rows[r].want);
      end
    end

    // Random phases over several register settings, extremes included
    clock_ms = 32'd7000;
    set_registers(32'd0, 32'd0, 32'd0);
    random_phase(PHASE_ITEMS, 1'b1);
    set_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_phase(PHASE_ITEMS, 1'b0);
    set_registers($urandom_range(1000, 60000), $urandom_range(1, 20000),
                  $urandom_range(0, 40000));
    random_phase(PHASE_ITEMS, 1'b1);
    set_registers(ALERT_THRESHOLD_RST, THROTTLE_RST, REPORT_FLOOR_RST);
    random_phase(PHASE_ITEMS, 1'b0);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Result receiver: random stalls, one long hold-off on request
  initial begin : result_sink
    int w;
    out_chan.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_request) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        w = calm ? 0 : $urandom_range(0, 3);
        if (w > 0) begin
          out_chan.ready <= 1'b0;
          repeat (w) @(posedge clk);
        end
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d label %h",
                                  out_chan.kind, out_chan.out_label));
      end else begin
        want_res = expected_results.pop_front();
        if (out_chan.kind !== want_res.kind)
          report_mismatch($sformatf("kind %0d, want %0d", out_chan.kind, want_res.kind));
        if (out_chan.out_label !== want_res.label)
          report_mismatch($sformatf("label %h, want %h", out_chan.out_label, want_res.label));
        if (out_chan.time_us !== want_res.time_us)
          report_mismatch($sformatf("time_us %0d, want %0d", out_chan.time_us,
                                    want_res.time_us));
        if (out_chan.overrun_count !== want_res.count)
          report_mismatch($sformatf("overrun_count %0d, want %0d", out_chan.overrun_count,
                                    want_res.count));
        if (out_chan.last !== want_res.last)
          report_mismatch($sformatf("last %b, want %b", out_chan.last, want_res.last));
      end
    end
  end

  // Hard stop if the run hangs
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/bts_pkg.sv
hw/rtl/bts_in_if.sv
hw/rtl/bts_out_if.sv
hw/rtl/bts_cfg_if.sv
hw/rtl/bts_ctrl.sv
hw/rtl/bts_dp.sv
hw/rtl/block_timing_stats_table_core.sv
bench/block_timing_stats_table_core_tb.sv
